[hw/rtl/c2s_pkg.sv]
// Package: widths, CORDIC arctangent table and gain constant for the spherical converter.
package c2s_pkg;
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD_BITS        = 6;
    localparam int ACC_W             = 34;
    localparam logic [23:0] KINV_Q24 = 24'd10188014;
    localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 34'sd1073741824;

    function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
                27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
                30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_entry = {2'b00, v};
        end
    endfunction
endpackage

[hw/rtl/c2s_cordic_stage.sv]
// One registered CORDIC vectoring micro-rotation with a sideband payload.
module c2s_cordic_stage import c2s_pkg::*; #(
    parameter int XW    = 24,
    parameter int SHIFT = 0,
    parameter int SBW   = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [XW-1:0]    i_x,
    input  logic signed [XW-1:0]    i_y,
    input  logic signed [ACC_W-1:0] i_ang,
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_valid,
    output logic signed [XW-1:0]    o_x,
    output logic signed [XW-1:0]    o_y,
    output logic signed [ACC_W-1:0] o_ang,
    output logic [SBW-1:0]          o_sb
);
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ACC_W-1:0] n_ang;
    localparam logic signed [ACC_W-1:0] ATAN = atan_entry(SHIFT);

    always_comb begin
        dx = i_y >>> SHIFT;
        dy = i_x >>> SHIFT;
        if (!i_y[XW-1]) begin
            n_x = i_x + dx; n_y = i_y - dy; n_ang = i_ang + ATAN;
        end else begin
            n_x = i_x - dx; n_y = i_y + dy; n_ang = i_ang - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x <= n_x; o_y <= n_y; o_ang <= n_ang; o_sb <= i_sb;
        end
    end
endmodule

[hw/rtl/c2s_vectoring.sv]
// Chain of CORDIC stages forming one vectoring pass.
module c2s_vectoring import c2s_pkg::*; #(
    parameter int XW     = 24,
    parameter int STAGES = 16,
    parameter int SBW    = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [XW-1:0]    i_x,
    input  logic signed [XW-1:0]    i_y,
    input  logic signed [ACC_W-1:0] i_ang,
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_valid,
    output logic signed [XW-1:0]    o_x,
    output logic signed [ACC_W-1:0] o_ang,
    output logic [SBW-1:0]          o_sb
);
    logic                    v [STAGES+1];
    logic signed [XW-1:0]    x [STAGES+1];
    logic signed [XW-1:0]    y [STAGES+1];
    logic signed [ACC_W-1:0] a [STAGES+1];
    logic [SBW-1:0]          s [STAGES+1];

    assign v[0] = i_valid; assign x[0] = i_x; assign y[0] = i_y;
    assign a[0] = i_ang;   assign s[0] = i_sb;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        c2s_cordic_stage #(.XW(XW), .SHIFT(g), .SBW(SBW)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_valid(v[g]), .i_x(x[g]), .i_y(y[g]), .i_ang(a[g]), .i_sb(s[g]),
            .o_valid(v[g+1]), .o_x(x[g+1]), .o_y(y[g+1]), .o_ang(a[g+1]),
            .o_sb(s[g+1])
        );
    end

    assign o_valid = v[STAGES];
    assign o_x     = x[STAGES];
    assign o_ang   = a[STAGES];
    assign o_sb    = s[STAGES];
endmodule

[hw/rtl/cartesian_to_spherical_unit.sv]
// Top level: Cartesian to spherical converter built from two CORDIC vectoring pipelines.
//
// Slave channel s_axis_*: one point per beat, tdata = {z, y, x}, x in the lowest bits.
// Master channel m_axis_*: one result per beat, tdata = {radius, elevation, azimuth}.
// Angles are binary angles, 32768 stands for pi; the radius is unsigned, rounded.
// From input beat to output beat a point passes the entry register, the first pass,
// the gain multiply, the second pass, the radius multiply and the output register
// with round and saturate. Unless the receiver stalls,
// throughput is one point per cycle, set by the fully pipelined stage chain.
// All stages advance together on a shared enable; an output register holds the
// result while the receiver stalls, and s_axis_tready stays high whenever that
// register is empty or being taken, so a stall holds every beat in place.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Points with x = y = 0 give azimuth 0; with z also 0 the elevation is 0.
module cartesian_to_spherical_unit import c2s_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // x_coord, y_coord, z_coord from the lowest bit up
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // azimuth_angle, elevation_angle, radius_len from the lowest bit up
    output logic [47:0]                m_axis_tdata
);
    localparam int CW  = COORD_WIDTH;
    localparam int XW  = CW + GUARD_BITS + 3;
    localparam int PW  = XW + 25;
    localparam int SB1 = CW + 2;

    logic en;
    logic r_out_valid;
    logic [47:0] r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // entry: pre-rotation into the right half plane
    logic signed [CW-1:0] xi, yi, zi;
    logic signed [XW-1:0] n_x0, n_y0;
    logic signed [ACC_W-1:0] n_a0;
    logic r_v0;
    logic signed [XW-1:0] r_x0, r_y0;
    logic signed [ACC_W-1:0] r_a0;
    logic [SB1-1:0] r_sb0;

    assign xi = s_axis_tdata[CW-1:0];
    assign yi = s_axis_tdata[2*CW-1:CW];
    assign zi = s_axis_tdata[3*CW-1:2*CW];

    always_comb begin
        logic signed [XW-1:0] xs, ys;
        xs = XW'(xi) <<< GUARD_BITS;
        ys = XW'(yi) <<< GUARD_BITS;
        n_x0 = xs; n_y0 = ys; n_a0 = '0;
        if (xi[CW-1]) begin
            if (!yi[CW-1]) begin
                n_x0 = ys; n_y0 = -xs; n_a0 = HALF_PI_ACC;
            end else begin
                n_x0 = -ys; n_y0 = xs; n_a0 = -HALF_PI_ACC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
        if (en) begin
            r_x0 <= n_x0; r_y0 <= n_y0; r_a0 <= n_a0;
            r_sb0 <= {zi, (xi == '0) && (yi == '0), zi == '0};
        end
    end

    logic v1;
    logic signed [XW-1:0] x1;
    logic signed [ACC_W-1:0] a1;
    logic [SB1-1:0] sb1;

    c2s_vectoring #(.XW(XW), .STAGES(CORDIC_STAGES), .SBW(SB1)) u_pass_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v0),
        .i_x(r_x0), .i_y(r_y0), .i_ang(r_a0), .i_sb(r_sb0),
        .o_valid(v1), .o_x(x1), .o_ang(a1), .o_sb(sb1)
    );

    // gain compensation of the planar magnitude
    logic r_vm;
    logic signed [XW-1:0] r_rxy, r_zm;
    logic [15:0] r_az;
    logic [1:0] r_flm;
    logic [PW-1:0] prod1;
    logic signed [ACC_W-1:0] az_fix;

    assign prod1  = PW'(unsigned'(x1)) * PW'(KINV_Q24) + PW'(1 << 23);
    assign az_fix = sb1[1] ? '0 : a1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= v1;
        end
        if (en) begin
            r_rxy <= XW'(prod1[PW-1:24]);
            r_zm  <= XW'(signed'(sb1[SB1-1:2])) <<< GUARD_BITS;
            r_az  <= 16'(ACC_W'(az_fix + ACC_W'(32768)) >>> 16);
            r_flm <= sb1[1:0];
        end
    end

    localparam int SB2 = 18;
    logic v2;
    logic signed [XW-1:0] x2;
    logic signed [ACC_W-1:0] a2;
    logic [SB2-1:0] sb2;

    c2s_vectoring #(.XW(XW), .STAGES(CORDIC_STAGES), .SBW(SB2)) u_pass_el (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm),
        .i_x(r_rxy), .i_y(r_zm), .i_ang('0), .i_sb({r_flm, r_az}),
        .o_valid(v2), .o_x(x2), .o_ang(a2), .o_sb(sb2)
    );

    // radius gain compensation, then round and saturate
    logic r_vr;
    logic [PW-1:0] r_prod2;
    logic [15:0] r_az2, r_el;
    logic signed [ACC_W-1:0] el_fix;
    logic [PW-1:0] rr;

    assign el_fix = (sb2[17] && sb2[16]) ? '0 : a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (en) begin
            r_vr <= v2;
        end
        if (en) begin
            r_prod2 <= PW'(unsigned'(x2)) * PW'(KINV_Q24) + PW'(1 << (23 + GUARD_BITS));
            r_az2   <= sb2[15:0];
            r_el    <= 16'(ACC_W'(el_fix + ACC_W'(32768)) >>> 16);
        end
    end

    assign rr = r_prod2 >> (24 + GUARD_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vr;
        end
        if (en) begin
            r_out_data <= {(rr > PW'(16'hFFFF)) ? 16'hFFFF : rr[15:0], r_el, r_az2};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vr))
        else $error("pipeline moved during stall");
endmodule
